@@ src/bvga_pkg.sv @@
package bvga_pkg;

	// Geometry of the volume layout.
	localparam int COORD_BITS = 14;
	localparam int BLOCK_LOG2 = 6;
	localparam int BRICK_LOG2 = 2;

	localparam int BLK_W = 1 << BLOCK_LOG2;
	localparam int BLK_STRIDE = BLK_W - 1;
	localparam int BRK_MASK = (1 << BRICK_LOG2) - 1;
	localparam int HI_BITS = BLOCK_LOG2 - BRICK_LOG2;
	localparam int SH_Y_LO = BRICK_LOG2;
	localparam int SH_Z_LO = 2 * BRICK_LOG2;
	localparam int SH_X_HI = 3 * BRICK_LOG2;
	localparam int SH_Y_HI = 3 * BRICK_LOG2 + HI_BITS;
	localparam int SH_Z_HI = 3 * BRICK_LOG2 + 2 * HI_BITS;

	// Block coordinate width: the stride is at least half the block width.
	localparam int QB = COORD_BITS - BLOCK_LOG2 + 1;

	// Reciprocal of the stride, rounded down; the quotient estimate is then
	// at most one short of the exact quotient.
	localparam int DIV_K = COORD_BITS + BLOCK_LOG2;
	localparam int DIV_MB = COORD_BITS + 2;
	localparam logic [DIV_MB-1:0] DIV_M = DIV_MB'((64'd1 << DIV_K) / 64'(BLK_STRIDE));

	// Fixed field widths.
	localparam int GRID_BITS = 9;
	localparam int VSL_BITS = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam int IDX_BITS = 25;
	localparam int OFS_BITS = 18;
	localparam int BYTE_BITS = 21;
	localparam int SX_BITS = 9;
	localparam int SY_BITS = 13;
	localparam int SZ_BITS = 17;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKS_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKS_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_VOXEL_SIZE = 2'd2;

	// Neighbour steps in elements, before scaling by the voxel size.
	localparam logic [31:0] STEP_X_NORM = 32'd1;
	localparam logic [31:0] STEP_X_EDGE = 32'((1 << SH_X_HI) - BRK_MASK);
	localparam logic [31:0] STEP_Y_NORM = 32'(1 << SH_Y_LO);
	localparam logic [31:0] STEP_Y_EDGE = 32'((1 << SH_Y_HI) - BRK_MASK * (1 << SH_Y_LO));
	localparam logic [31:0] STEP_Z_NORM = 32'(1 << SH_Z_LO);
	localparam logic [31:0] STEP_Z_EDGE = 32'((1 << SH_Z_HI) - BRK_MASK * (1 << SH_Z_LO));

	typedef logic [QB-1:0] bcoord_t;
	typedef logic [BLOCK_LOG2-1:0] pos_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] voxel_x;
		logic [COORD_BITS-1:0] voxel_y;
		logic [COORD_BITS-1:0] voxel_z;
		logic ghost_dx;
		logic ghost_dy;
		logic ghost_dz;
	} voxel_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] block_index;
		logic [OFS_BITS-1:0] voxel_offset;
		logic [BYTE_BITS-1:0] byte_offset;
		logic [SX_BITS-1:0] step_x;
		logic [SY_BITS-1:0] step_y;
		logic [SZ_BITS-1:0] step_z;
		logic ghost_valid;
		logic [IDX_BITS-1:0] ghost_block_index;
		logic [OFS_BITS-1:0] ghost_voxel_offset;
	} addr_t;

	typedef struct packed {
		logic [GRID_BITS-1:0] blocks_x;
		logic [GRID_BITS-1:0] blocks_y;
		logic [VSL_BITS-1:0] voxel_size_log2;
	} cfg_t;

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

@@ src/bvga_div.sv @@
module bvga_div (
	input  logic                             clk,
	input  bvga_pkg::pipe_en_t               en,
	input  logic [bvga_pkg::COORD_BITS-1:0]  coord,
	output bvga_pkg::bcoord_t                blk,
	output bvga_pkg::pos_t                   pos
);

	localparam int CB = bvga_pkg::COORD_BITS;
	localparam int BL = bvga_pkg::BLOCK_LOG2;
	localparam int PROD_W = CB + bvga_pkg::DIV_MB;
	localparam int RW = CB + 1;

	logic [PROD_W-1:0]    prod;
	logic [CB-1:0]        coord_s1;
	bvga_pkg::bcoord_t    quot_s1;
	logic [RW-1:0]        qd;
	logic [RW-1:0]        rem;
	logic                 fix;
	bvga_pkg::bcoord_t    blk_s2;
	bvga_pkg::pos_t       pos_s2;

	assign prod = PROD_W'(coord) * PROD_W'(bvga_pkg::DIV_M);

	// Stage 1: quotient estimate from the reciprocal product.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			coord_s1 <= coord;
			quot_s1 <= prod[bvga_pkg::DIV_K +: bvga_pkg::QB];
		end
	end

	// The estimate may be one short; one compare and subtract corrects it.
	assign qd = (RW'(quot_s1) << BL) - RW'(quot_s1);
	assign rem = RW'(coord_s1) - qd;
	assign fix = (rem >= RW'(bvga_pkg::BLK_STRIDE));

	always_ff @(posedge clk) begin
		if (en.s2) begin
			blk_s2 <= fix ? quot_s1 + bvga_pkg::bcoord_t'(1) : quot_s1;
			pos_s2 <= fix ? BL'(rem - RW'(bvga_pkg::BLK_STRIDE)) : BL'(rem);
		end
	end

	assign blk = blk_s2;
	assign pos = pos_s2;

endmodule

@@ src/bvga_addr.sv @@
module bvga_addr (
	input  logic                 clk,
	input  bvga_pkg::pipe_en_t   en,
	input  bvga_pkg::cfg_t       cfg,
	input  bvga_pkg::bcoord_t    blk [3],
	input  bvga_pkg::pos_t       pos [3],
	input  logic [2:0]           dir,
	output bvga_pkg::addr_t      res
);

	localparam int BL = bvga_pkg::BLOCK_LOG2;
	localparam int BR = bvga_pkg::BRICK_LOG2;
	localparam int IW = bvga_pkg::IDX_BITS;

	function automatic logic [bvga_pkg::OFS_BITS-1:0] pack_ofs(
		bvga_pkg::pos_t x, bvga_pkg::pos_t y, bvga_pkg::pos_t z);
		logic [3*BL-1:0] v;
		v = {z[BL-1:BR], y[BL-1:BR], x[BL-1:BR], z[BR-1:0], y[BR-1:0], x[BR-1:0]};
		return bvga_pkg::OFS_BITS'(v);
	endfunction

	logic [2:0]          mv;
	logic [2:0]          neg;
	logic [2:0]          edge_hit;
	bvga_pkg::bcoord_t   gb [3];
	bvga_pkg::pos_t      gp [3];
	logic                gvalid;
	logic [31:0]         sx_w;
	logic [31:0]         sy_w;
	logic [31:0]         sz_w;
	logic [bvga_pkg::OFS_BITS-1:0] ofs;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mv[i] = (pos[i] == '0) && dir[i];
			neg[i] = mv[i] && (blk[i] == '0);
			gb[i] = mv[i] ? blk[i] - bvga_pkg::bcoord_t'(1) : blk[i];
			gp[i] = mv[i] ? bvga_pkg::pos_t'(bvga_pkg::BLK_W - 1) : pos[i];
			edge_hit[i] = &pos[i][BR-1:0];
		end
	end

	assign gvalid = (|mv) && !(|neg);
	assign ofs = pack_ofs(pos[0], pos[1], pos[2]);
	assign sx_w = (edge_hit[0] ? bvga_pkg::STEP_X_EDGE : bvga_pkg::STEP_X_NORM)
		<< cfg.voxel_size_log2;
	assign sy_w = (edge_hit[1] ? bvga_pkg::STEP_Y_EDGE : bvga_pkg::STEP_Y_NORM)
		<< cfg.voxel_size_log2;
	assign sz_w = (edge_hit[2] ? bvga_pkg::STEP_Z_EDGE : bvga_pkg::STEP_Z_NORM)
		<< cfg.voxel_size_log2;

	// Stage 3: inner term of the linear index, offsets and steps.
	logic [IW-1:0]                  t_s3;
	logic [IW-1:0]                  gt_s3;
	bvga_pkg::bcoord_t              bx_s3;
	bvga_pkg::bcoord_t              gbx_s3;
	logic                           gvalid_s3;
	logic [bvga_pkg::OFS_BITS-1:0]  ofs_s3;
	logic [bvga_pkg::OFS_BITS-1:0]  gofs_s3;
	logic [bvga_pkg::BYTE_BITS-1:0] byte_s3;
	logic [bvga_pkg::SX_BITS-1:0]   sx_s3;
	logic [bvga_pkg::SY_BITS-1:0]   sy_s3;
	logic [bvga_pkg::SZ_BITS-1:0]   sz_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			t_s3 <= IW'(blk[1]) + IW'(cfg.blocks_y) * IW'(blk[2]);
			gt_s3 <= IW'(gb[1]) + IW'(cfg.blocks_y) * IW'(gb[2]);
			bx_s3 <= blk[0];
			gbx_s3 <= gb[0];
			gvalid_s3 <= gvalid;
			ofs_s3 <= ofs;
			gofs_s3 <= gvalid ? pack_ofs(gp[0], gp[1], gp[2]) : '0;
			byte_s3 <= bvga_pkg::BYTE_BITS'(ofs) << cfg.voxel_size_log2;
			sx_s3 <= sx_w[bvga_pkg::SX_BITS-1:0];
			sy_s3 <= sy_w[bvga_pkg::SY_BITS-1:0];
			sz_s3 <= sz_w[bvga_pkg::SZ_BITS-1:0];
		end
	end

	// Stage 4: outer term of the linear index, into the output register.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			res.block_index <= IW'(bx_s3) + IW'(cfg.blocks_x) * t_s3;
			res.voxel_offset <= ofs_s3;
			res.byte_offset <= byte_s3;
			res.step_x <= sx_s3;
			res.step_y <= sy_s3;
			res.step_z <= sz_s3;
			res.ghost_valid <= gvalid_s3;
			res.ghost_block_index <= gvalid_s3 ?
				IW'(gbx_s3) + IW'(cfg.blocks_x) * gt_s3 : '0;
			res.ghost_voxel_offset <= gofs_s3;
		end
	end

endmodule

@@ src/bricked_volume_ghost_address.sv @@
// Bricked volume address translation with ghost-voxel lookup.
//
// The voxel channel (voxel_valid, voxel_ready, voxel) takes three coordinates
// and three ghost direction bits per item. The addr channel (addr_valid,
// addr_ready, addr) returns one result item per input item, in order: the
// linear block index, the brick-interleaved offset, its byte form, the
// neighbour steps and the ghost copy address.
// An accepted item passes through every pipeline stage before addr_valid
// rises, and a ready receiver then takes it from the output register.
// One item is taken every cycle while the receiver is ready or a stage is free;
// the pipeline has four stages: the reciprocal multiply of the divide by the
// block stride, its one-step correction, the inner and the outer grid multiply.
// Each stage has its own valid bit and moves when the stage after it is
// empty or moving, so bubbles are squeezed out and voxel_ready stays high
// while any stage is free, even when the receiver stalls. A stalled result
// is held in the output register until it is taken.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the grid size
// and voxel size; it should be written only while no item is in flight.
// Reset empties the pipeline and sets a 1 by 1 grid of byte voxels.
module bricked_volume_ghost_address_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                voxel_valid,
	output logic                                voxel_ready,
	input  bvga_pkg::voxel_t                    voxel,
	output logic                                addr_valid,
	input  logic                                addr_ready,
	output bvga_pkg::addr_t                     addr,
	input  logic                                cfg_we,
	input  logic [bvga_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bvga_pkg::GRID_BITS-1:0]      cfg_data
);

	bvga_pkg::cfg_t     cfg_q;
	bvga_pkg::pipe_en_t en;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;
	logic [2:0]         dir_s1;
	logic [2:0]         dir_s2;
	bvga_pkg::bcoord_t  blk [3];
	bvga_pkg::pos_t     pos [3];

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blocks_x <= bvga_pkg::GRID_BITS'(1);
			cfg_q.blocks_y <= bvga_pkg::GRID_BITS'(1);
			cfg_q.voxel_size_log2 <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bvga_pkg::REG_BLOCKS_X: cfg_q.blocks_x <= cfg_data;
				bvga_pkg::REG_BLOCKS_Y: cfg_q.blocks_y <= cfg_data;
				bvga_pkg::REG_VOXEL_SIZE:
					cfg_q.voxel_size_log2 <= cfg_data[bvga_pkg::VSL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it loads.
	assign en.s4 = !valid_s4 || addr_ready;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;
	assign voxel_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= voxel_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	// The ghost direction bits ride alongside the divider stages.
	always_ff @(posedge clk) begin
		if (en.s1) dir_s1 <= {voxel.ghost_dz, voxel.ghost_dy, voxel.ghost_dx};
		if (en.s2) dir_s2 <= dir_s1;
	end

	bvga_div u_div_x (
		.clk   (clk),
		.en    (en),
		.coord (voxel.voxel_x),
		.blk   (blk[0]),
		.pos   (pos[0])
	);

	bvga_div u_div_y (
		.clk   (clk),
		.en    (en),
		.coord (voxel.voxel_y),
		.blk   (blk[1]),
		.pos   (pos[1])
	);

	bvga_div u_div_z (
		.clk   (clk),
		.en    (en),
		.coord (voxel.voxel_z),
		.blk   (blk[2]),
		.pos   (pos[2])
	);

	bvga_addr u_addr (
		.clk (clk),
		.en  (en),
		.cfg (cfg_q),
		.blk (blk),
		.pos (pos),
		.dir (dir_s2),
		.res (addr)
	);

	assign addr_valid = valid_s4;

	// A result can only appear in the output register from a full stage 3.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s4) |-> $past(valid_s3))
		else $error("output valid without a stage 3 item");

	// An empty first stage always takes a new item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> voxel_ready)
		else $error("input stalled with stage 1 empty");

	// The byte offset follows the element offset and the voxel size.
	assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid |-> addr.byte_offset ==
			(bvga_pkg::BYTE_BITS'(addr.voxel_offset) << cfg_q.voxel_size_log2))
		else $error("byte offset does not match element offset");

	// An invalid ghost carries a zero address.
	assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && !addr.ghost_valid |->
			addr.ghost_block_index == '0 && addr.ghost_voxel_offset == '0)
		else $error("invalid ghost with a non-zero address");

endmodule
